// ----- sv/tcp_option_parser_top_macros.svh -----
// ---------------------------------------------------------------------------
// TCP option parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef TCP_OPTION_PARSER_TOP_MACROS_SVH
`define TCP_OPTION_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define TOP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TOP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcp_opt_pkg.sv -----
// ---------------------------------------------------------------------------
// TCP option parser package
// Option kinds, lengths, summary record type and result packing.
// ---------------------------------------------------------------------------
package tcp_opt_pkg;

  localparam int MAX_BLOCKS     = 4;
  localparam int MAX_AREA_BYTES = 40;
  localparam int OUT_DATA_W     = 96;

  localparam logic [7:0] KIND_EOL     = 8'd0;
  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_WSCALE  = 8'd3;
  localparam logic [7:0] KIND_SACK_OK = 8'd4;
  localparam logic [7:0] KIND_SACK    = 8'd5;
  localparam logic [7:0] KIND_TS      = 8'd8;

  localparam logic [7:0] LEN_MIN      = 8'd2;
  localparam logic [7:0] LEN_SACK_OK  = 8'd2;
  localparam logic [7:0] LEN_WSCALE   = 8'd3;
  localparam logic [7:0] LEN_MSS      = 8'd4;
  localparam logic [7:0] LEN_TS       = 8'd10;
  localparam logic [7:0] LEN_SACK_MIN = 8'd10;

  localparam logic [7:0] WSCALE_LIMIT = 8'd14;

  // Position within the current option
  localparam logic [5:0] OFF_KIND      = 6'd0;
  localparam logic [5:0] OFF_LEN       = 6'd1;
  localparam logic [5:0] OFF_DATA      = 6'd2;
  localparam logic [5:0] OFF_TSVAL_END = 6'd5;
  localparam logic [5:0] OFF_TSECR_END = 6'd9;

  // Byte within an 8-byte SACK block at which each edge word completes
  localparam logic [2:0] SACK_START_END = 3'd3;
  localparam logic [2:0] SACK_EDGE_END  = 3'd7;

  localparam logic REC_SUMMARY = 1'b0;
  localparam logic REC_SACK    = 1'b1;

  typedef struct packed {
    logic        parse_ok;
    logic        has_mss;
    logic [15:0] mss_value;
    logic        has_wscale;
    logic [3:0]  wscale_value;
    logic        has_sack_ok;
    logic        has_ts;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [2:0]  sack_count;
  } summary_t;

  // SACK length is 2 + 8*n with n >= 1
  function automatic logic sack_len_ok(input logic [7:0] len);
    return (len >= LEN_SACK_MIN) && (len[2:0] == 3'd2);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] pack_record(input summary_t s);
    return {4'b0, s.sack_count, s.word_b, s.word_a, s.has_ts, s.has_sack_ok,
            s.wscale_value, s.has_wscale, s.mss_value, s.has_mss, s.parse_ok};
  endfunction

endpackage

// ----- sv/tcp_option_parser_top.sv -----
// ---------------------------------------------------------------------------
// TCP option parser top level
// Parses the TCP option area byte by byte and emits summary and SACK records.
// ---------------------------------------------------------------------------
// Throughput: one option byte per cycle except while a closing byte waits.
// A closing byte's summary goes via the emitter snapshot to the output
//   register; SACK records follow at one per cycle under no backpressure.
// A closing byte waits until the last of the previous area's 1 to 1+MaxBlocks
//   records moves into the output register.
// Reset (rst_ni, async, active low) clears parse and handshake state at once.
module tcp_option_parser_top
  import tcp_opt_pkg::*;
#(
  parameter int MaxBlocks = MAX_BLOCKS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave side: one option byte per transaction
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] data_byte
  input  logic                  s_axis_tlast_i,   // last_byte
  input  logic                  s_axis_tuser_i,   // [0] empty_area
  // Master side: one record per transaction
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] parse_ok, [1] has_mss, [17:2] mss_value, [18] has_wscale,
  // [22:19] wscale_value, [23] has_sack_ok, [24] has_ts,
  // [56:25] word_a, [88:57] word_b, [91:89] sack_count, [95:92] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,   // last_result
  output logic                  m_axis_tuser_o    // [0] record_kind
);

  logic        snap_free;
  logic        snap_load;
  summary_t    summary;
  logic [31:0] blk_start [MaxBlocks];
  logic [31:0] blk_end   [MaxBlocks];

  // Byte stage: input register and parse state; hold a closing byte until
  // the emitter can take the snapshot
  tcp_opt_parse #(
    .MaxBlocks (MaxBlocks)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_byte_i    (s_axis_tdata_i),
    .s_last_i    (s_axis_tlast_i),
    .s_empty_i   (s_axis_tuser_i),
    .snap_free_i (snap_free),
    .snap_load_o (snap_load),
    .summary_o   (summary),
    .blk_start_o (blk_start),
    .blk_end_o   (blk_end)
  );

  // Emitter: copy of the closed area, then advance through its records into
  // the output register, so the next area parses while these drain
  tcp_opt_emit #(
    .MaxBlocks (MaxBlocks)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_load_i (snap_load),
    .summary_i   (summary),
    .blk_start_i (blk_start),
    .blk_end_i   (blk_end),
    .snap_free_o (snap_free),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_last_o    (m_axis_tlast_o),
    .m_user_o    (m_axis_tuser_o)
  );

endmodule

// ----- sv/tcp_opt_parse.sv -----
// ---------------------------------------------------------------------------
// TCP option parser byte stage
// Registers one option byte and updates the parse state from it.
// ---------------------------------------------------------------------------
module tcp_opt_parse
  import tcp_opt_pkg::*;
#(
  parameter  int MaxBlocks = MAX_BLOCKS,
  localparam int BlkW      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [7:0]  s_byte_i,
  input  logic        s_last_i,
  input  logic        s_empty_i,
  input  logic        snap_free_i,
  output logic        snap_load_o,
  output summary_t    summary_o,
  output logic [31:0] blk_start_o [MaxBlocks],
  output logic [31:0] blk_end_o   [MaxBlocks]
);

  localparam logic [5:0] AreaLimit = 6'(MAX_AREA_BYTES);
  localparam logic [4:0] MaxN      = 5'(MaxBlocks);

  logic        in_v_q, in_v_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q, in_empty_q;

  logic [5:0]  pos_q, pos_d, off_q, off_d;
  logic [7:0]  kind_q, kind_d, len_q, len_d;
  logic        end_q, end_d, err_q, err_d;
  logic [31:0] ws_q, ws_d;
  logic        mss_flag_q, mss_flag_d;
  logic [15:0] mss_val_q, mss_val_d;
  logic        wsc_flag_q, wsc_flag_d;
  logic [3:0]  wsc_val_q, wsc_val_d;
  logic        sackok_q, sackok_d;
  logic        ts_flag_q, ts_flag_d;
  logic [31:0] tsval_q, tsval_d, tsecr_q, tsecr_d;
  logic [2:0]  stored_q, stored_d;
  logic [31:0] start_q [MaxBlocks];
  logic [31:0] start_d [MaxBlocks];
  logic [31:0] edge_q  [MaxBlocks];
  logic [31:0] edge_d  [MaxBlocks];

  logic        close, consume, take;
  logic [31:0] ws_new;
  logic [5:0]  rel;
  logic [2:0]  blk;
  logic [4:0]  n_blk;
  logic        err_fin;
  logic [2:0]  cnt;

  assign close       = in_empty_q || in_last_q;
  assign consume     = !close || snap_free_i;
  assign s_ready_o   = !in_v_q || consume;
  assign take        = in_v_q && consume && !in_empty_q;
  assign snap_load_o = in_v_q && close && snap_free_i;

  assign ws_new = {ws_q[23:0], in_byte_q};
  assign rel    = off_q - OFF_DATA;
  assign blk    = rel[5:3];
  assign n_blk  = in_byte_q[7:3];

  assign in_v_d = s_ready_o ? s_valid_i : in_v_q;

  always_comb begin
    pos_d      = pos_q;
    off_d      = off_q;
    kind_d     = kind_q;
    len_d      = len_q;
    end_d      = end_q;
    err_d      = err_q;
    ws_d       = ws_q;
    mss_flag_d = mss_flag_q;
    mss_val_d  = mss_val_q;
    wsc_flag_d = wsc_flag_q;
    wsc_val_d  = wsc_val_q;
    sackok_d   = sackok_q;
    ts_flag_d  = ts_flag_q;
    tsval_d    = tsval_q;
    tsecr_d    = tsecr_q;
    stored_d   = stored_q;
    start_d    = start_q;
    edge_d     = edge_q;

    if (take) begin
      if (pos_q >= AreaLimit) begin
        err_d = 1'b1;
      end else begin
        pos_d = pos_q + 6'd1;
        if (!err_q && !end_q) begin
          case (off_q)
            OFF_KIND: begin
              if (in_byte_q == KIND_EOL) begin
                end_d = 1'b1;
              end else if (in_byte_q != KIND_NOP) begin
                kind_d = in_byte_q;
                off_d  = OFF_LEN;
              end
            end
            OFF_LEN: begin
              if (in_byte_q < LEN_MIN) begin
                err_d = 1'b1;
              end else begin
                len_d = in_byte_q;
                ws_d  = 32'd0;
                if (kind_q == KIND_SACK && sack_len_ok(in_byte_q)) begin
                  stored_d = (n_blk > MaxN) ? MaxN[2:0] : n_blk[2:0];
                end
                if (in_byte_q == LEN_SACK_OK) begin
                  if (kind_q == KIND_SACK_OK) sackok_d = 1'b1;
                  off_d = OFF_KIND;
                end else begin
                  off_d = OFF_DATA;
                end
              end
            end
            default: begin
              ws_d = ws_new;
              if (kind_q == KIND_SACK && sack_len_ok(len_q) && blk < stored_q) begin
                if (rel[2:0] == SACK_START_END) begin
                  start_d[blk[BlkW-1:0]] = ws_new;
                end else if (rel[2:0] == SACK_EDGE_END) begin
                  edge_d[blk[BlkW-1:0]] = ws_new;
                end
              end
              if (kind_q == KIND_TS && len_q == LEN_TS) begin
                if (off_q == OFF_TSVAL_END) tsval_d = ws_new;
                else if (off_q == OFF_TSECR_END) tsecr_d = ws_new;
              end
              if ({2'b00, off_q} + 8'd1 == len_q) begin
                if (kind_q == KIND_MSS && len_q == LEN_MSS) begin
                  mss_flag_d = 1'b1;
                  mss_val_d  = ws_new[15:0];
                end else if (kind_q == KIND_WSCALE && len_q == LEN_WSCALE) begin
                  wsc_flag_d = 1'b1;
                  wsc_val_d  = (in_byte_q > WSCALE_LIMIT) ? WSCALE_LIMIT[3:0]
                                                          : in_byte_q[3:0];
                end else if (kind_q == KIND_TS && len_q == LEN_TS) begin
                  ts_flag_d = 1'b1;
                end
                off_d = OFF_KIND;
              end else begin
                off_d = off_q + 6'd1;
              end
            end
          endcase
        end
      end
    end

    // Summary from the state after this byte
    err_fin = err_d || (!end_d && off_d != OFF_KIND);
    cnt     = err_fin ? 3'd0 : stored_d;
    summary_o                = '0;
    summary_o.parse_ok       = !err_fin;
    if (!err_fin) begin
      summary_o.has_mss      = mss_flag_d;
      summary_o.mss_value    = mss_flag_d ? mss_val_d : 16'd0;
      summary_o.has_wscale   = wsc_flag_d;
      summary_o.wscale_value = wsc_flag_d ? wsc_val_d : 4'd0;
      summary_o.has_sack_ok  = sackok_d;
      summary_o.has_ts       = ts_flag_d;
      summary_o.word_a       = ts_flag_d ? tsval_d : 32'd0;
      summary_o.word_b       = ts_flag_d ? tsecr_d : 32'd0;
      summary_o.sack_count   = cnt;
    end
    blk_start_o = start_d;
    blk_end_o   = edge_d;

    // Clear the area state once it closes
    if (snap_load_o) begin
      pos_d      = '0;
      off_d      = OFF_KIND;
      kind_d     = '0;
      len_d      = '0;
      end_d      = 1'b0;
      err_d      = 1'b0;
      ws_d       = '0;
      mss_flag_d = 1'b0;
      mss_val_d  = '0;
      wsc_flag_d = 1'b0;
      wsc_val_d  = '0;
      sackok_d   = 1'b0;
      ts_flag_d  = 1'b0;
      tsval_d    = '0;
      tsecr_d    = '0;
      stored_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      pos_q      <= '0;
      off_q      <= OFF_KIND;
      kind_q     <= '0;
      len_q      <= '0;
      end_q      <= 1'b0;
      err_q      <= 1'b0;
      ws_q       <= '0;
      mss_flag_q <= 1'b0;
      mss_val_q  <= '0;
      wsc_flag_q <= 1'b0;
      wsc_val_q  <= '0;
      sackok_q   <= 1'b0;
      ts_flag_q  <= 1'b0;
      tsval_q    <= '0;
      tsecr_q    <= '0;
      stored_q   <= '0;
    end else begin
      in_v_q     <= in_v_d;
      pos_q      <= pos_d;
      off_q      <= off_d;
      kind_q     <= kind_d;
      len_q      <= len_d;
      end_q      <= end_d;
      err_q      <= err_d;
      ws_q       <= ws_d;
      mss_flag_q <= mss_flag_d;
      mss_val_q  <= mss_val_d;
      wsc_flag_q <= wsc_flag_d;
      wsc_val_q  <= wsc_val_d;
      sackok_q   <= sackok_d;
      ts_flag_q  <= ts_flag_d;
      tsval_q    <= tsval_d;
      tsecr_q    <= tsecr_d;
      stored_q   <= stored_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_byte_q  <= s_byte_i;
      in_last_q  <= s_last_i;
      in_empty_q <= s_empty_i;
    end
    start_q <= start_d;
    edge_q  <= edge_d;
  end

endmodule

// ----- sv/tcp_opt_emit.sv -----
// ---------------------------------------------------------------------------
// TCP option parser record emitter
// Holds a closed area's summary and blocks, one out per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "tcp_option_parser_top_macros.svh"

module tcp_opt_emit
  import tcp_opt_pkg::*;
#(
  parameter  int MaxBlocks = MAX_BLOCKS,
  localparam int BlkW      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_load_i,
  input  summary_t              summary_i,
  input  logic [31:0]           blk_start_i [MaxBlocks],
  input  logic [31:0]           blk_end_i   [MaxBlocks],
  output logic                  snap_free_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic                  m_last_o,
  output logic                  m_user_o
);

  localparam logic [2:0] MaxCnt = 3'(MaxBlocks);

  logic                  busy_q, busy_d;
  logic [2:0]            idx_q, idx_d;
  summary_t              snap_q;
  logic [31:0]           start_q [MaxBlocks];
  logic [31:0]           edge_q  [MaxBlocks];
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_last_q, m_user_q;

  logic                  out_load, rec_last;
  logic [2:0]            idx_m1;
  summary_t              sack_rec;
  logic                  err_clean;

  // Free again in the cycle that the last record moves to the output register
  assign snap_free_o = !busy_q || (out_load && rec_last);
  assign out_load    = busy_q && (!m_valid_q || m_ready_i);
  assign rec_last    = (idx_q == snap_q.sack_count);
  assign idx_m1      = idx_q - 3'd1;
  assign err_clean   = (summary_i.sack_count == 3'd0) && !summary_i.has_mss &&
                       !summary_i.has_ts;

  always_comb begin
    sack_rec          = '0;
    sack_rec.parse_ok = 1'b1;
    sack_rec.word_a   = start_q[idx_m1[BlkW-1:0]];
    sack_rec.word_b   = edge_q[idx_m1[BlkW-1:0]];
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (snap_load_i) begin
      busy_d = 1'b1;
      idx_d  = 3'd0;
    end else if (out_load) begin
      if (rec_last) busy_d = 1'b0;
      else idx_d = idx_q + 3'd1;
    end
    if (out_load) m_valid_d = 1'b1;
    else if (m_ready_i) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load_i) begin
      snap_q  <= summary_i;
      start_q <= blk_start_i;
      edge_q  <= blk_end_i;
    end
    if (out_load) begin
      m_last_q <= rec_last;
      if (idx_q == 3'd0) begin
        m_data_q <= pack_record(snap_q);
        m_user_q <= REC_SUMMARY;
      end else begin
        m_data_q <= pack_record(sack_rec);
        m_user_q <= REC_SACK;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_user_o  = m_user_q;

  `TOP_ASSERT_IMP(a_load_when_free, snap_load_i, !busy_q || rec_last, "snapshot loaded while busy")
  `TOP_ASSERT_NXT(a_load_starts, snap_load_i, busy_q && idx_q == 3'd0, "load did not restart")
  `TOP_ASSERT_IMP(a_idx_bound, busy_q, idx_q <= snap_q.sack_count, "record index overran")
  `TOP_ASSERT_IMP(a_cnt_bound, busy_q, snap_q.sack_count <= MaxCnt, "block count over limit")
  `TOP_ASSERT_IMP(a_err_clean, snap_load_i && !summary_i.parse_ok, err_clean, "error not clean")

endmodule

// ----- test/tcp_option_parser_top_tb.sv -----
// ---------------------------------------------------------------------------
// TCP option parser testbench
// Streams option areas into the parser, byte by byte. A scoreboard parses the
// same bytes on its own and queues the summary and SACK block records it
// expects. Every record that leaves the block is checked field by field. A
// short directed sequence comes first, then random areas: mostly well-formed
// option lists with random content, plus truncated, badly sized, oversized,
// empty and noise areas. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tcp_option_parser_top_tb
  import tcp_opt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 20;
  localparam int ITEM_TARGET  = 400;
  localparam int AREA_TARGET  = 24;

  // One expected output record
  typedef struct {
    logic     kind;
    summary_t sum;
    logic     last;
  } option_record_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  // -------------------------------------------------------------------------
  // Scoreboard: parses every accepted byte and holds the records it implies
  // -------------------------------------------------------------------------
  class option_scoreboard;
    option_record_t expected_records[$];
    int             failures;
    int             areas_closed;
    int             error_areas;
    int             sack_records;

    int unsigned    byte_pos;
    int unsigned    opt_off;
    bit [7:0]       opt_kind;
    bit [7:0]       opt_len;
    bit             end_seen;
    bit             err_seen;
    bit [31:0]      shift_word;
    bit             mss_seen;
    bit [15:0]      mss_val;
    bit             ws_seen;
    bit [3:0]       ws_val;
    bit             sack_perm;
    bit             ts_seen;
    bit [31:0]      ts_val;
    bit [31:0]      ts_ecr;
    bit [31:0]      blk_start[MAX_BLOCKS];
    bit [31:0]      blk_end[MAX_BLOCKS];
    int unsigned    blocks_held;

    function new();
      failures     = 0;
      areas_closed = 0;
      error_areas  = 0;
      sack_records = 0;
      clear_area();
    endfunction

    function int outstanding();
      return expected_records.size();
    endfunction

    function void clear_area();
      byte_pos    = 0;
      opt_off     = OFF_KIND;
      opt_kind    = '0;
      opt_len     = '0;
      end_seen    = 1'b0;
      err_seen    = 1'b0;
      shift_word  = '0;
      mss_seen    = 1'b0;
      mss_val     = '0;
      ws_seen     = 1'b0;
      ws_val      = '0;
      sack_perm   = 1'b0;
      ts_seen     = 1'b0;
      ts_val      = '0;
      ts_ecr      = '0;
      blocks_held = 0;
    endfunction

    // SACK option carries 2 + 8*n bytes, n at least one
    function bit sack_length_valid(bit [7:0] len);
      return (len >= LEN_SACK_MIN) && (((len - 8'd2) % 8) == 0);
    endfunction

    function void take_option_data(bit [7:0] b);
      int unsigned off;
      int unsigned rel;
      int unsigned blk;
      off = opt_off;
      shift_word = {shift_word[23:0], b};

      if (opt_kind == KIND_SACK && sack_length_valid(opt_len)) begin
        rel = off - 2;
        blk = rel >> 3;
        if (blk < blocks_held) begin
          if ((rel % 8) == SACK_START_END)
            blk_start[blk] = shift_word;
          else if ((rel % 8) == SACK_EDGE_END)
            blk_end[blk] = shift_word;
        end
      end
      if (opt_kind == KIND_TS && opt_len == LEN_TS) begin
        if (off == OFF_TSVAL_END)
          ts_val = shift_word;
        else if (off == OFF_TSECR_END)
          ts_ecr = shift_word;
      end

      if (off + 1 == opt_len) begin
        if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
          mss_seen = 1'b1;
          mss_val  = shift_word[15:0];
        end else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE) begin
          ws_seen = 1'b1;
          ws_val  = (b > WSCALE_LIMIT) ? WSCALE_LIMIT[3:0] : b[3:0];
        end else if (opt_kind == KIND_TS && opt_len == LEN_TS) begin
          ts_seen = 1'b1;
        end
        opt_off = OFF_KIND;
      end else begin
        opt_off = off + 1;
      end
    endfunction

    function void take_option_byte(bit [7:0] b);
      int unsigned n;
      if (byte_pos >= MAX_AREA_BYTES) begin
        err_seen = 1'b1;
        return;
      end
      byte_pos++;
      if (err_seen || end_seen)
        return;

      if (opt_off == OFF_KIND) begin
        if (b == KIND_EOL) begin
          end_seen = 1'b1;
        end else if (b != KIND_NOP) begin
          opt_kind = b;
          opt_off  = OFF_LEN;
        end
      end else if (opt_off == OFF_LEN) begin
        if (b < LEN_MIN) begin
          err_seen = 1'b1;
          return;
        end
        opt_len    = b;
        shift_word = '0;
        if (opt_kind == KIND_SACK && sack_length_valid(b)) begin
          n = (b - 2) / 8;
          blocks_held = (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
        end
        if (b == LEN_MIN) begin
          if (opt_kind == KIND_SACK_OK)
            sack_perm = 1'b1;
          opt_off = OFF_KIND;
        end else begin
          opt_off = OFF_DATA;
        end
      end else begin
        take_option_data(b);
      end
    endfunction

    function void close_area();
      option_record_t rec;
      bit             ok;
      int unsigned    cnt;
      if (!end_seen && opt_off != OFF_KIND)
        err_seen = 1'b1;
      ok  = !err_seen;
      cnt = ok ? blocks_held : 0;

      rec.kind         = REC_SUMMARY;
      rec.sum          = '0;
      rec.sum.parse_ok = ok;
      if (ok) begin
        rec.sum.has_mss      = mss_seen;
        rec.sum.mss_value    = mss_seen ? mss_val : 16'd0;
        rec.sum.has_wscale   = ws_seen;
        rec.sum.wscale_value = ws_seen ? ws_val : 4'd0;
        rec.sum.has_sack_ok  = sack_perm;
        rec.sum.has_ts       = ts_seen;
        rec.sum.word_a       = ts_seen ? ts_val : 32'd0;
        rec.sum.word_b       = ts_seen ? ts_ecr : 32'd0;
        rec.sum.sack_count   = 3'(cnt);
      end else begin
        error_areas++;
      end
      rec.last = (cnt == 0);
      expected_records.push_back(rec);

      for (int k = 0; k < cnt; k++) begin
        rec.kind         = REC_SACK;
        rec.sum          = '0;
        rec.sum.parse_ok = 1'b1;
        rec.sum.word_a   = blk_start[k];
        rec.sum.word_b   = blk_end[k];
        rec.last         = (k == cnt - 1);
        expected_records.push_back(rec);
        sack_records++;
      end
      areas_closed++;
      clear_area();
    endfunction

    // Note one accepted input transaction
    function void note_item(bit [7:0] data, bit last, bit empty);
      if (!empty)
        take_option_byte(data);
      if (!empty && !last)
        return;
      close_area();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    // Check one accepted output transaction against the oldest expectation
    function void check_record(logic kind, logic [OUT_DATA_W-1:0] d, logic last);
      option_record_t want;
      if (expected_records.size() == 0) begin
        $error("record_kind %0b arrived with no record expected", kind);
        failures++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("record_kind",  want.kind,             kind);
      compare_field("parse_ok",     want.sum.parse_ok,     d[0]);
      compare_field("has_mss",      want.sum.has_mss,      d[1]);
      compare_field("mss_value",    want.sum.mss_value,    d[17:2]);
      compare_field("has_wscale",   want.sum.has_wscale,   d[18]);
      compare_field("wscale_value", want.sum.wscale_value, d[22:19]);
      compare_field("has_sack_ok",  want.sum.has_sack_ok,  d[23]);
      compare_field("has_ts",       want.sum.has_ts,       d[24]);
      compare_field("word_a",       want.sum.word_a,       d[56:25]);
      compare_field("word_b",       want.sum.word_b,       d[88:57]);
      compare_field("sack_count",   want.sum.sack_count,   d[91:89]);
      compare_field("tdata_pad",    4'd0,                  d[95:92]);
      compare_field("last_result",  want.last,             last);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block under test
  // -------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  s_tvalid      = 1'b0;
  logic [7:0]            s_tdata       = '0;
  logic                  s_tlast       = 1'b0;
  logic                  s_tuser       = 1'b0;
  logic                  m_tready      = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;

  option_scoreboard sb;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tcp_option_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // -------------------------------------------------------------------------
  // Transaction monitor: sample both sides at the edge, before any update
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_tvalid && s_axis_tready_o)
        sb.note_item(s_tdata, s_tlast, s_tuser);
      if (m_axis_tvalid_o && m_tready)
        sb.check_record(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Watchdog: end the run if the block hangs
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d records outstanding", cycles, sb.outstanding());
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall in phases of random length, each with its own pattern.
  // A requested hold-off keeps the output stalled without a break, so the
  // block backs up and stalls its input while the sender keeps offering.
  // -------------------------------------------------------------------------
  rx_mode_e rx_mode       = RX_OPEN;
  int       rx_phase_left = 0;
  bit [7:0] rx_pattern    = '0;
  int       hold_left     = 0;
  bit       hold_pending  = 1'b0;

  always @(posedge clk_i) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_e'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(20, 80);
        rx_pattern    = 8'($urandom);
      end
      rx_phase_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_tready   <= rx_pattern[0];
          rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, or gap-free stretches
  // -------------------------------------------------------------------------
  int       burst_left = 0;
  bit       no_gaps    = 1'b0;
  int       items_sent = 0;
  int       areas_sent = 0;
  bit [7:0] area_q[$];
  bit [7:0] opt_q[$];

  // Offer one transaction and hold it until the block takes it
  task automatic send_item(bit [7:0] data, bit last, bit empty);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    s_tuser  <= empty;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // Send area_q; close with an empty transaction if asked or if no bytes
  task automatic send_area(bit close_empty);
    int n;
    n = area_q.size();
    for (int i = 0; i < n; i++)
      send_item(area_q[i], !close_empty && (i == n - 1), 1'b0);
    if (close_empty || n == 0)
      send_item(8'($urandom), 1'($urandom), 1'b1);
    areas_sent++;
  endtask

  // Hold the input idle until every expected record has come out
  task automatic drain_outputs();
    s_tvalid   <= 1'b0;
    burst_left  = 0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  function automatic void push_random(int n);
    repeat (n) opt_q.push_back(8'($urandom));
  endfunction

  // Build one option into opt_q
  function automatic void make_option();
    bit [7:0] wrong_kinds[5];
    bit [7:0] right_lens[5];
    int       idx;
    int       nblk;
    int       len;
    bit [7:0] kind;
    wrong_kinds = '{KIND_MSS, KIND_WSCALE, KIND_SACK_OK, KIND_SACK, KIND_TS};
    right_lens  = '{LEN_MSS, LEN_WSCALE, LEN_SACK_OK, LEN_SACK_MIN, LEN_TS};
    opt_q.delete();
    case ($urandom_range(0, 9))
      0: opt_q.push_back(KIND_NOP);
      1: begin
        opt_q.push_back(KIND_MSS);
        opt_q.push_back(LEN_MSS);
        push_random(2);
      end
      2: begin
        opt_q.push_back(KIND_WSCALE);
        opt_q.push_back(LEN_WSCALE);
        // stay near the clamp most of the time
        opt_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 16)) : 8'($urandom));
      end
      3: begin
        opt_q.push_back(KIND_SACK_OK);
        opt_q.push_back(LEN_SACK_OK);
      end
      4: begin
        opt_q.push_back(KIND_TS);
        opt_q.push_back(LEN_TS);
        push_random(8);
      end
      5, 6: begin
        nblk = $urandom_range(1, 4);
        opt_q.push_back(KIND_SACK);
        opt_q.push_back(8'(2 + 8 * nblk));
        push_random(8 * nblk);
      end
      7: begin
        // unknown kind, skipped by its length
        kind = 8'($urandom_range(6, 255));
        if (kind == KIND_TS)
          kind = 8'd254;
        len = $urandom_range(2, 8);
        opt_q.push_back(kind);
        opt_q.push_back(8'(len));
        push_random(len - 2);
      end
      8: begin
        // known kind with a length it does not own
        idx = $urandom_range(0, 4);
        len = $urandom_range(2, 12);
        if (len == right_lens[idx])
          len++;
        opt_q.push_back(wrong_kinds[idx]);
        opt_q.push_back(8'(len));
        push_random(len - 2);
      end
      default: begin
        opt_q.push_back(KIND_EOL);
        push_random($urandom_range(0, 3));
      end
    endcase
  endfunction

  // Append up to n options, skipping any that would overrun the area
  function automatic void fill_wellformed(int n);
    repeat (n) begin
      make_option();
      if (area_q.size() + opt_q.size() <= MAX_AREA_BYTES)
        foreach (opt_q[i]) area_q.push_back(opt_q[i]);
    end
  endfunction

  function automatic void build_random_area(output bit close_empty);
    int pick;
    int cut;
    int target;
    area_q.delete();
    opt_q.delete();
    close_empty = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      fill_wellformed($urandom_range(1, 6));
    end else if (pick < 70) begin
      // well-formed list with its tail cut off
      fill_wellformed($urandom_range(1, 4));
      if (area_q.size() > 1) begin
        cut = $urandom_range(1, area_q.size() - 1);
        repeat (cut) void'(area_q.pop_back());
      end
    end else if (pick < 75) begin
      // length byte below the minimum
      fill_wellformed($urandom_range(0, 2));
      area_q.push_back(8'($urandom_range(2, 255)));
      area_q.push_back(8'($urandom_range(0, 1)));
      push_random($urandom_range(0, 3));
      foreach (opt_q[i]) area_q.push_back(opt_q[i]);
    end else if (pick < 80) begin
      // pad to the area limit or just beyond it
      fill_wellformed($urandom_range(0, 3));
      target = $urandom_range(MAX_AREA_BYTES, MAX_AREA_BYTES + 4);
      if ($urandom_range(0, 1))
        area_q.push_back(KIND_EOL);
      while (area_q.size() < target)
        area_q.push_back(KIND_NOP);
    end else if (pick < 87) begin
      close_empty = 1'b1;
    end else if (pick < 93) begin
      push_random($urandom_range(1, 12));
      foreach (opt_q[i]) area_q.push_back(opt_q[i]);
    end else begin
      fill_wellformed($urandom_range(1, 4));
      close_empty = 1'b1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    bit close_empty;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Zero-length area: one empty transaction
    area_q.delete();
    send_area(1'b0);
    // MSS at its maximum, window scale above the clamp, SACK-permitted, NOP, EOL
    area_q = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WSCALE, LEN_WSCALE, 8'hFF,
               KIND_SACK_OK, LEN_SACK_OK, KIND_NOP, KIND_EOL};
    send_area(1'b0);
    // One SACK block, start all zeros and end all ones
    area_q = '{KIND_SACK, LEN_SACK_MIN, 8'h00, 8'h00, 8'h00, 8'h00,
               8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_area(1'b0);
    // Length byte below the minimum
    area_q = '{KIND_MSS, 8'd1};
    send_area(1'b0);
    // Option data cut short by the close
    area_q = '{KIND_WSCALE, LEN_WSCALE};
    send_area(1'b0);
    // Length byte missing
    area_q = '{8'd200};
    send_area(1'b0);
    // NOP closed by an empty transaction
    area_q = '{KIND_NOP};
    send_area(1'b1);
    drain_outputs();

    while (items_sent < ITEM_TARGET || areas_sent < AREA_TARGET) begin
      // Stall the output for a long stretch while the sender keeps going
      if (areas_sent == 14)
        hold_pending = 1'b1;
      // Let every expected record out before going on
      if (areas_sent == 20)
        drain_outputs();
      if ($urandom_range(0, 7) == 0)
        no_gaps = !no_gaps;
      build_random_area(close_empty);
      send_area(close_empty);
    end

    drain_outputs();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $error("%0d expected records never arrived", sb.outstanding());
      sb.failures++;
    end

    $display("Run covered %0d input transactions over %0d option areas.",
             items_sent, sb.areas_closed);
    $display("Records checked: %0d summaries (%0d malformed areas), %0d SACK blocks.",
             sb.areas_closed, sb.error_areas, sb.sack_records);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tcp_opt_pkg.sv
sv/tcp_opt_parse.sv
sv/tcp_opt_emit.sv
sv/tcp_option_parser_top.sv
test/tcp_option_parser_top_tb.sv
